// ===== hw/rtl/dbcf_pkg.sv =====
`default_nettype none

package dbcf_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int TIME_W     = 32;
	localparam int PIN_W      = 32;
	localparam int DATA_W     = 8;
	localparam int SIG_W      = 9;
	localparam int DB_W       = 8;
	localparam int CNT_W      = 32;
	localparam int FRAME_W    = TIME_W + DATA_W + SIG_W;

	localparam int            DATA_BASE_PIN  = 2;
	localparam logic [DB_W-1:0] DEADBAND_RESET = DB_W'(3);

	// strobe, ack, busy, autofeed, init, selectin, paperout, select, error
	localparam logic [4:0] SIGNAL_PINS [SIG_W] = '{
		5'd10, 5'd11, 5'd12, 5'd21, 5'd19, 5'd18, 5'd14, 5'd15, 5'd20
	};

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_COALESCED = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] frame_time;
		logic [DATA_W-1:0] frame_data;
		logic [SIG_W-1:0]  frame_signals;
	} frame_t;

	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] time_us;
		logic [PIN_W-1:0]  pin_snapshot;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] drop_count;
	} tag_t;

	function automatic idx_t next_slot(input idx_t i);
		return (i == idx_t'(RING_DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic logic [SIG_W-1:0] gather_signals(input logic [PIN_W-1:0] pins);
		logic [SIG_W-1:0] s;
		s = '0;
		for (int k = 0; k < SIG_W; k++) begin
			s[k] = pins[SIGNAL_PINS[k]];
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dbcf_req_if.sv =====
`default_nettype none

interface dbcf_req_if;
	import dbcf_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 op;
	logic [TIME_W-1:0]   time_us;
	logic [PIN_W-1:0]    pin_snapshot;

	modport source (output valid, output op, output time_us, output pin_snapshot, input ready);
	modport sink   (input valid, input op, input time_us, input pin_snapshot, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dbcf_rsp_if.sv =====
`default_nettype none

interface dbcf_rsp_if;
	import dbcf_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [TIME_W-1:0]   frame_time;
	logic [DATA_W-1:0]   frame_data;
	logic [SIG_W-1:0]    frame_signals;
	logic [CNT_W-1:0]    drop_count;

	modport source (output valid, output status, output frame_time, output frame_data,
		output frame_signals, output drop_count, input ready);
	modport sink   (input valid, input status, input frame_time, input frame_data,
		input frame_signals, input drop_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dbcf_cfg_if.sv =====
`default_nettype none

interface dbcf_cfg_if;
	import dbcf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DB_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/deadband_edge_capture_fifo_top.sv =====
`default_nettype none

// Timestamped edge capture queue. Each request transaction is either an edge
// (op 0: timestamp plus raw pin snapshot) or a pop (op 1), and yields exactly
// one response transaction, in order. An edge whose timestamp lies within
// deadband_us of the last accepted edge (mod 2^32) is coalesced; otherwise it
// becomes the new reference time and is stored as a frame (timestamp, data
// byte from pins 2..9, nine parallel-port status bits), or counted in
// drop_count when the ring already holds RING_DEPTH-1 frames. A pop returns
// the oldest frame or reports empty; frame fields are zero on every other
// response. Throughput is one transaction per cycle while rsp.ready does not
// stall the output; a response passes through the registered read of the frame
// memory and then the output register. The frame memory needs no clearing
// pass after reset. Write deadband_us on the cfg channel only while idle.
module deadband_edge_capture_fifo_top (
	input wire logic  clk,
	input wire logic  arst_n,
	dbcf_cfg_if.sink  cfg,
	dbcf_req_if.sink  req,
	dbcf_rsp_if.source rsp
);
	import dbcf_pkg::*;

	logic   take;
	logic   advance;
	item_t  item;
	tag_t   tag;
	logic   ram_we;
	idx_t   ram_waddr;
	frame_t ram_wdata;
	logic   ram_re;
	idx_t   ram_raddr;
	frame_t ram_rdata;

	logic   valid_s1;
	tag_t   tag_s1;
	logic   out_valid_q;

	// Advance the stage-one transaction when the output register is free or draining.
	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign item = '{op: req.op, time_us: req.time_us, pin_snapshot: req.pin_snapshot};

	dbcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_data  (cfg.data),
		.take      (take),
		.item      (item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.tag       (tag)
	);

	// Read data holds until the next pop is taken, which cannot happen while
	// stage one is stalled.
	dbcf_ram #(
		.DEPTH (RING_DEPTH),
		.WIDTH (FRAME_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Load the response; zero the frame fields unless a frame was popped.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp.status     <= tag_s1.status;
			rsp.drop_count <= tag_s1.drop_count;
			if (tag_s1.status == ST_POPPED) begin
				rsp.frame_time    <= ram_rdata.frame_time;
				rsp.frame_data    <= ram_rdata.frame_data;
				rsp.frame_signals <= ram_rdata.frame_signals;
			end else begin
				rsp.frame_time    <= '0;
				rsp.frame_data    <= '0;
				rsp.frame_signals <= '0;
			end
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dbcf_ram.sv =====
`default_nettype none

module dbcf_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 49
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dbcf_ctrl.sv =====
`default_nettype none

module dbcf_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [dbcf_pkg::DB_W-1:0] cfg_data,
	input  wire logic                      take,
	input  wire dbcf_pkg::item_t           item,
	output      logic                      ram_we,
	output      dbcf_pkg::idx_t            ram_waddr,
	output      dbcf_pkg::frame_t          ram_wdata,
	output      logic                      ram_re,
	output      dbcf_pkg::idx_t            ram_raddr,
	output      dbcf_pkg::tag_t            tag
);
	import dbcf_pkg::*;

	logic [DB_W-1:0]   deadband_q;
	logic [TIME_W-1:0] last_time_q;
	logic [CNT_W-1:0]  lost_q;
	idx_t              wr_idx_q;
	idx_t              rd_idx_q;

	logic [TIME_W-1:0] delta;
	logic              coalesce;
	logic              full;
	logic              empty;
	idx_t              wr_next;
	idx_t              rd_next;
	logic [CNT_W-1:0]  lost_next;

	always_comb begin
		delta     = item.time_us - last_time_q;
		coalesce  = (delta <= TIME_W'(deadband_q));
		wr_next   = next_slot(wr_idx_q);
		rd_next   = next_slot(rd_idx_q);
		full      = (wr_next == rd_idx_q);
		empty     = (rd_idx_q == wr_idx_q);
		lost_next = lost_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		unique case (item.op)
			OP_EDGE: begin
				if (coalesce) begin
					tag.status = ST_COALESCED;
				end else if (full) begin
					tag.status = ST_DROPPED;
					lost_next  = lost_q + CNT_W'(1);
				end else begin
					tag.status = ST_STORED;
					ram_we     = take;
				end
			end
			OP_POP: begin
				if (empty) begin
					tag.status = ST_EMPTY;
				end else begin
					tag.status = ST_POPPED;
					ram_re     = take;
				end
			end
			default: tag.status = ST_EMPTY;
		endcase
		tag.drop_count = lost_next;
	end

	assign ram_waddr = wr_idx_q;
	assign ram_raddr = rd_idx_q;
	assign ram_wdata = '{
		frame_time:    item.time_us,
		frame_data:    item.pin_snapshot[DATA_BASE_PIN +: DATA_W],
		frame_signals: gather_signals(item.pin_snapshot)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_we) begin
			deadband_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			lost_q      <= '0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
		end else if (take) begin
			lost_q <= lost_next;
			if (item.op == OP_EDGE && !coalesce) begin
				last_time_q <= item.time_us;
			end
			if (ram_we) begin
				wr_idx_q <= wr_next;
			end
			if (ram_re) begin
				rd_idx_q <= rd_next;
			end
		end
	end

endmodule

`default_nettype wire
